// File: rtl/tkh_pkg.sv
package tkh_pkg;

  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;

  // slot index, child index (one spare bit for 2i+2) and slot count widths
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CHILD_W = IDX_W + 2;
  localparam int NUM_W   = $clog2(CAPACITY + 1);

  localparam int CAP_CFG_W  = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CAP_CFG_W-1:0] CAP_RESET = CAP_CFG_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEEP_LARGEST = 1'b0,
    REG_CAPACITY     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_OFFER   = 1'b0,
    OP_READOUT = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [KEY_BITS-1:0]     item_key;
    logic [PAYLOAD_BITS-1:0] item_payload;
  } item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    out_valid;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    out_last;
  } result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFFER_CHK,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_RD_VISIT,
    S_RD_CAPT,
    S_RD_NEXT,
    S_RD_UP,
    S_RD_END
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic rd_root;
    logic rd_children;
    logic write_carried;
    logic write_child;
    logic emit_accept;
    logic emit_reject;
    logic go_left;
    logic go_sib;
    logic go_parent;
    logic capture;
    logic emit_final;
  } ctrl_cmd_t;

  typedef struct packed {
    logic enter;
    logic swap;
    logic left_ok;
    logic sib_ok;
    logic is_root;
    logic occ_idx;
  } dp_status_t;

  // strict rank compare: a is worse than b
  function automatic logic key_worse(input logic keep_largest,
                                     input logic [KEY_BITS-1:0] a,
                                     input logic [KEY_BITS-1:0] b);
    return keep_largest ? (a < b) : (a > b);
  endfunction

endpackage

// File: rtl/tkh_ram.sv
module tkh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                        rdata_a,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/tkh_ctrl.sv
module tkh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tkh_pkg::opcode_t    opcode,
  input  tkh_pkg::dp_status_t status,
  output tkh_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  import tkh_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_OFFER) ? S_OFFER_CHK : S_RD_VISIT;
        end
      end
      S_OFFER_CHK: state_next = status.enter ? S_SIFT_RD : S_IDLE;
      S_SIFT_RD:   state_next = status.left_ok ? S_SIFT_CMP : S_IDLE;
      S_SIFT_CMP:  state_next = status.swap ? S_SIFT_RD : S_IDLE;
      S_RD_VISIT:  state_next = status.occ_idx ? S_RD_CAPT : S_RD_NEXT;
      S_RD_CAPT:   state_next = S_RD_NEXT;
      S_RD_NEXT:   state_next = status.left_ok ? S_RD_VISIT : S_RD_UP;
      S_RD_UP: begin
        if (status.is_root) begin
          state_next = S_RD_END;
        end else if (status.sib_ok) begin
          state_next = S_RD_VISIT;
        end
      end
      S_RD_END:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.rd_root   = 1'b1;
        cmd.load_item = start;
      end
      S_OFFER_CHK: cmd.emit_reject = !status.enter;
      S_SIFT_RD: begin
        cmd.rd_children   = 1'b1;
        // leaf reached: the carried item settles here
        cmd.write_carried = !status.left_ok;
        cmd.emit_accept   = !status.left_ok;
      end
      S_SIFT_CMP: begin
        cmd.write_child   = status.swap;
        cmd.write_carried = !status.swap;
        cmd.emit_accept   = !status.swap;
      end
      S_RD_VISIT: ;
      S_RD_CAPT:  cmd.capture = 1'b1;
      S_RD_NEXT:  cmd.go_left = status.left_ok;
      S_RD_UP: begin
        cmd.go_sib    = !status.is_root && status.sib_ok;
        cmd.go_parent = !status.is_root && !status.sib_ok;
      end
      S_RD_END:   cmd.emit_final = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/tkh_datapath.sv
module tkh_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tkh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tkh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  tkh_pkg::item_t                      item,
  input  tkh_pkg::ctrl_cmd_t                  cmd,
  output tkh_pkg::dp_status_t                 status,
  output logic                                result_strobe,
  output tkh_pkg::result_t                    result
);

  import tkh_pkg::*;

  localparam int SLOT_W = $bits(slot_t);

  logic                 keep_largest;
  logic [CAP_CFG_W-1:0] capacity_in_use;
  logic [NUM_W-1:0]     num_slots;

  item_t                item_reg;
  logic [IDX_W-1:0]     idx;
  logic [CAPACITY-1:0]  occ;
  slot_t                pend;
  logic                 have_pend;

  logic [CHILD_W-1:0]   left_c, right_c, sib_c, num_ext;
  logic [IDX_W-1:0]     left_idx, right_idx, parent_idx;

  logic [IDX_W-1:0]     raddr_a;
  logic [SLOT_W-1:0]    rdata_a_raw, rdata_b_raw, wdata_raw;
  slot_t                rd_l, rd_r, wslot;
  logic                 we;

  logic                 occ_l, occ_r, right_ok;
  logic                 r_worse_l, pick_r, l_worse_c, r_worse_c;

  logic                 result_strobe_next;
  result_t              result_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_largest    <= 1'b0;
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_LARGEST: keep_largest    <= cfg_wdata[0];
        REG_CAPACITY:     capacity_in_use <= cfg_wdata[CAP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (capacity_in_use == '0) begin
      num_slots = NUM_W'(1);
    end else if (int'(capacity_in_use) > CAPACITY) begin
      num_slots = NUM_W'(CAPACITY);
    end else begin
      num_slots = NUM_W'(capacity_in_use);
    end
  end

  // tree navigation
  assign left_c     = {1'b0, idx, 1'b1};
  assign right_c    = left_c + CHILD_W'(1);
  assign sib_c      = CHILD_W'(idx) + CHILD_W'(1);
  assign num_ext    = CHILD_W'(num_slots);
  assign left_idx   = left_c[IDX_W-1:0];
  assign right_idx  = right_c[IDX_W-1:0];
  assign parent_idx = (idx - IDX_W'(1)) >> 1;
  assign right_ok   = (right_c < num_ext);

  // slot storage
  assign raddr_a = cmd.rd_children ? left_idx : (cmd.rd_root ? '0 : idx);

  tkh_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .we      (we),
    .waddr   (idx),
    .wdata   (wdata_raw),
    .raddr_a (raddr_a),
    .raddr_b (right_idx),
    .rdata_a (rdata_a_raw),
    .rdata_b (rdata_b_raw)
  );

  assign rd_l = rdata_a_raw;
  assign rd_r = rdata_b_raw;

  // sift compare: an empty slot ranks worst, ties pick the left child
  assign occ_l = occ[left_idx];
  assign occ_r = occ[right_idx];

  always_comb begin
    if (!occ_r) begin
      r_worse_l = occ_l;
    end else if (!occ_l) begin
      r_worse_l = 1'b0;
    end else begin
      r_worse_l = key_worse(keep_largest, rd_r.key, rd_l.key);
    end
  end

  assign pick_r    = right_ok && r_worse_l;
  assign l_worse_c = !occ_l || key_worse(keep_largest, rd_l.key, item_reg.item_key);
  assign r_worse_c = !occ_r || key_worse(keep_largest, rd_r.key, item_reg.item_key);

  always_comb begin
    if (cmd.write_child) begin
      wslot = pick_r ? rd_r : rd_l;
    end else begin
      wslot.key     = item_reg.item_key;
      wslot.payload = item_reg.item_payload;
    end
  end

  assign wdata_raw = wslot;
  assign we        = cmd.write_carried || cmd.write_child;

  assign status.enter   = !occ[0] || key_worse(keep_largest, rd_l.key, item_reg.item_key);
  assign status.swap    = pick_r ? r_worse_c : l_worse_c;
  assign status.left_ok = (left_c < num_ext);
  assign status.sib_ok  = idx[0] && (sib_c < num_ext);
  assign status.is_root = (idx == '0);
  assign status.occ_idx = occ[idx];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_reg <= item;
    end
    if (cmd.capture) begin
      pend <= rd_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      idx       <= '0;
      have_pend <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        idx       <= '0;
        have_pend <= 1'b0;
      end
      if (cmd.write_carried) begin
        occ[idx] <= 1'b1;
      end
      if (cmd.write_child) begin
        occ[idx] <= pick_r ? occ_r : occ_l;
        idx      <= pick_r ? right_idx : left_idx;
      end
      if (cmd.go_left) begin
        idx <= left_idx;
      end
      if (cmd.go_sib) begin
        idx <= sib_c[IDX_W-1:0];
      end
      if (cmd.go_parent) begin
        idx <= parent_idx;
      end
      if (cmd.capture) begin
        have_pend <= 1'b1;
      end
    end
  end

  // results: a readout holds one found slot back so the last one gets out_last
  always_comb begin
    result_next        = result;
    result_strobe_next = 1'b0;
    if (cmd.emit_accept || cmd.emit_reject) begin
      result_next.accepted    = cmd.emit_accept;
      result_next.out_valid   = 1'b0;
      result_next.out_key     = '0;
      result_next.out_payload = '0;
      result_next.out_last    = 1'b1;
      result_strobe_next      = 1'b1;
    end else if ((cmd.capture && have_pend) || cmd.emit_final) begin
      result_next.accepted    = 1'b0;
      result_next.out_valid   = have_pend;
      result_next.out_key     = have_pend ? pend.key : '0;
      result_next.out_payload = have_pend ? pend.payload : '0;
      result_next.out_last    = cmd.emit_final;
      result_strobe_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= result_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// File: rtl/top_k_bounded_heap.sv
// channel   | ports                              | transfer
// ----------+------------------------------------+-------------------------------
// command   | start, busy, item                  | start && !busy at a rising edge
// result    | result_strobe, result              | one cycle per strobe, no stall
// config    | cfg_we, cfg_index, cfg_wdata       | cfg_we at a rising edge
//
// Offer: a root check (S_IDLE reads the root, S_OFFER_CHK compares), then for
//   each level sifted one read of both children from the slot RAM (S_SIFT_RD)
//   and one compare/write step (S_SIFT_CMP).
// Readout: a preorder walk that visits each slot in use and climbs back up to the root.
// Reset (rst, synchronous): heap empty, keep smallest, 16 slots in use.
// The result side cannot stall; busy stays high until the last result.
module top_k_bounded_heap (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tkh_pkg::item_t                 item,
  output logic                           result_strobe,
  output tkh_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [tkh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tkh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tkh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tkh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tkh_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item          (item),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_last_ends_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.out_last |-> !busy)
    else $error("final result while still busy");

  a_mid_is_readout: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.out_last |-> busy && result.out_valid)
    else $error("non-final result outside a readout");

  a_offer_shape: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.accepted |-> !result.out_valid && result.out_last)
    else $error("accepted offer result carries readout data");

endmodule

// File: tb/top_k_bounded_heap_test.sv
module top_k_bounded_heap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tkh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic result_strobe;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  top_k_bounded_heap DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // heap shadow state and its configuration
  logic [KEY_BITS-1:0] heap_key[CAPACITY];
  logic [PAYLOAD_BITS-1:0] heap_pay[CAPACITY];
  bit heap_occ[CAPACITY];
  logic keep_largest_m = 1'b0;
  logic [CAP_CFG_W-1:0] cap_m = CAP_RESET;

  item_t pending_items[$];
  result_t results_due[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  function automatic int active_slots();
    if (cap_m == 0) return 1;
    if (cap_m > CAPACITY) return CAPACITY;
    return int'(cap_m);
  endfunction

  function automatic bit ranks_below(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    return keep_largest_m ? (a < b) : (a > b);
  endfunction

  // empty slot is worst; two empties rank equal
  function automatic bit slot_below(int a, int b);
    if (!heap_occ[a]) return heap_occ[b];
    if (!heap_occ[b]) return 1'b0;
    return ranks_below(heap_key[a], heap_key[b]);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [KEY_BITS-1:0] k;
    logic [PAYLOAD_BITS-1:0] p;
    bit o;
    k = heap_key[a]; p = heap_pay[a]; o = heap_occ[a];
    heap_key[a] = heap_key[b]; heap_pay[a] = heap_pay[b]; heap_occ[a] = heap_occ[b];
    heap_key[b] = k; heap_pay[b] = p; heap_occ[b] = o;
  endfunction

  function automatic void heap_sift_down(int n);
    int i;
    int l;
    int r;
    int w;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l >= n) return;
      w = l;
      if (r < n && slot_below(r, l)) w = r;
      if (!slot_below(w, i)) return;
      swap_slots(i, w);
      i = w;
    end
  endfunction

  function automatic void predict_heap_step(item_t it);
    int n;
    int i;
    bit enter;
    int walk[$];
    result_t r;
    result_t dump[$];
    n = active_slots();
    if (it.opcode == OP_OFFER) begin
      enter = !heap_occ[0] || ranks_below(heap_key[0], it.item_key);
      if (enter) begin
        heap_key[0] = it.item_key;
        heap_pay[0] = it.item_payload;
        heap_occ[0] = 1'b1;
        heap_sift_down(n);
      end
      r = '0;
      r.accepted = enter;
      r.out_last = 1'b1;
      results_due.push_back(r);
    end else begin
      // preorder walk: node, left subtree, right subtree
      walk.push_back(0);
      while (walk.size() != 0) begin
        i = walk.pop_back();
        if (i < n) begin
          if (heap_occ[i]) begin
            r = '0;
            r.out_valid = 1'b1;
            r.out_key = heap_key[i];
            r.out_payload = heap_pay[i];
            dump.push_back(r);
          end
          walk.push_back(2 * i + 2);
          walk.push_back(2 * i + 1);
        end
      end
      if (dump.size() == 0) begin
        r = '0;
        r.out_last = 1'b1;
        dump.push_back(r);
      end else begin
        dump[dump.size() - 1].out_last = 1'b1;
      end
      foreach (dump[j]) results_due.push_back(dump[j]);
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // command driver
  int gap_left = 0;
  always @(posedge clk) begin : drive
    bit taken;
    bit start_n;
    int gap_n;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) predict_heap_step(item);
      start_n = start && !taken;
      gap_n = taken ? pick_gap() : gap_left;
      if (!start_n) begin
        if (gap_n != 0) begin
          gap_n = gap_n - 1;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          start_n = 1'b1;
        end
      end
      start <= start_n;
      gap_left <= gap_n;
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && result_strobe) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: %p", result);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (result.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
          mismatches++;
        end
        if (result.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, result.out_valid);
          mismatches++;
        end
        if (result.out_key !== want.out_key) begin
          $error("out_key: expected %h, got %h", want.out_key, result.out_key);
          mismatches++;
        end
        if (result.out_payload !== want.out_payload) begin
          $error("out_payload: expected %h, got %h", want.out_payload, result.out_payload);
          mismatches++;
        end
        if (result.out_last !== want.out_last) begin
          $error("out_last: expected %0d, got %0d", want.out_last, result.out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL top_k_bounded_heap");
    $finish;
  end

  task automatic offer(logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p);
    item_t it;
    it.opcode = OP_OFFER;
    it.item_key = k;
    it.item_payload = p;
    pending_items.push_back(it);
  endtask

  task automatic readout();
    item_t it;
    it.opcode = OP_READOUT;
    it.item_key = $urandom;
    it.item_payload = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || start || results_due.size() != 0 || busy)
      @(negedge clk);
  endtask

  // only called while idle, so the shadow config can follow immediately
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEEP_LARGEST) keep_largest_m = val[0];
    else cap_m = val[CAP_CFG_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] random_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return KEY_BITS'($urandom_range(0, 15));
    if (roll < 60) return '1 - KEY_BITS'($urandom_range(0, 3));
    if (roll < 70) return KEY_BITS'($urandom_range(0, 3));
    return $urandom;
  endfunction

  initial begin : stimulus
    logic [CAP_CFG_W-1:0] cap_pick;
    int burst;
    foreach (heap_occ[i]) begin
      heap_occ[i] = 1'b0;
      heap_key[i] = '0;
      heap_pay[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: keep smallest, all slots
    readout();
    offer('1, '1);
    offer('0, '0);
    offer(32'd5, 32'h1234_5678);
    offer(32'd5, 32'h8765_4321);
    offer(32'd5, 32'hA5A5_5A5A);
    readout();
    wait_idle();

    // single slot, keep largest: equal and worse keys bounce off the root
    write_reg(REG_KEEP_LARGEST, CFG_DATA_W'(1));
    write_reg(REG_CAPACITY, CFG_DATA_W'(1));
    offer(32'd10, 32'h0000_0010);
    offer(32'd10, 32'h0000_0011);
    offer(32'd9, 32'h0000_0009);
    offer(32'd11, 32'h0000_0011);
    offer('1, 32'hFFFF_0000);
    readout();
    wait_idle();

    // zero capacity acts as one slot
    write_reg(REG_CAPACITY, CFG_DATA_W'(0));
    offer(32'd3, 32'h3333_3333);
    readout();
    wait_idle();

    // oversized capacity clamps; stale slots come back into view
    write_reg(REG_CAPACITY, CFG_DATA_W'(31));
    readout();
    wait_idle();
    write_reg(REG_KEEP_LARGEST, CFG_DATA_W'(0));
    offer(32'd1, 32'h0101_0101);
    offer(32'd2, 32'h0202_0202);
    offer(32'd7, 32'h0707_0707);
    readout();
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap_pick = 5'd16;
        1: cap_pick = 5'd3;
        2: cap_pick = 5'd31;
        3: cap_pick = 5'd1;
        4: cap_pick = 5'd0;
        default: cap_pick = 5'($urandom_range(0, 31));
      endcase
      write_reg(REG_KEEP_LARGEST, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_CAPACITY, cap_pick);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(11, 15);
      for (int n = 0; n < burst; n++) begin
        if ($urandom_range(0, 99) < 15) readout();
        else offer(random_key(), $urandom);
      end
      readout();
      wait_idle();
    end

    gaps_on = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS top_k_bounded_heap");
    end else begin
      $display("FAIL top_k_bounded_heap");
    end
    $finish;
  end

endmodule
